FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define DCSM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dcsm assertion failed");

// Checked at every edge, reset cycles included.
`define DCSM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dcsm assertion failed");

`endif

FILE: hdl/dcsm_pkg.sv
`default_nettype none

package dcsm_pkg;

    localparam int COUNTER_BITS = 16;

    localparam int CAP_W     = 16;
    localparam int OVF_W     = 16;
    localparam int ELAPSED_W = 32;
    localparam int NUM_W     = 32;
    localparam int SPEED_W   = 32;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_MASK = (COUNTER_BITS >= CAP_W) ? {CAP_W{1'b1}} :
        CAP_W'((64'd1 << COUNTER_BITS) - 64'd1);
    localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

    localparam logic [NUM_W-1:0] NUM_A_RESET = NUM_W'(612837);
    localparam logic [NUM_W-1:0] NUM_B_RESET = NUM_W'(306418);

    localparam logic FUNC_CAPTURE  = 1'b0;
    localparam logic FUNC_OVERFLOW = 1'b1;

    localparam logic REG_NUM_A = 1'b0;
    localparam logic REG_NUM_B = 1'b1;

    // The queue depth must be a power of two so that the pointers wrap freely.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS = SPEED_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                 channel;
        logic [ELAPSED_W-1:0] elapsed;
        logic [NUM_W-1:0]     numerator;
    } entry_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/dcsm_front.sv
`default_nettype none

module dcsm_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dcsm_pkg::IN_DATA_W-1:0] s_tdata,  // capture_value
    input  wire logic [dcsm_pkg::IN_USER_W-1:0] s_tuser,  // func, channel
    input  wire logic [dcsm_pkg::NUM_W-1:0]     num_a,
    input  wire logic [dcsm_pkg::NUM_W-1:0]     num_b,
    input  wire logic                           q_full,
    output logic                                q_push,
    output dcsm_pkg::entry_t                    q_entry
);
    import dcsm_pkg::*;

    logic [CAP_W-1:0] last_reg [2];
    logic [CAP_W-1:0] last_next [2];
    logic [OVF_W-1:0] ovf_reg [2];
    logic [OVF_W-1:0] ovf_next [2];

    logic             accept;
    logic             func;
    logic             ch;
    logic [CAP_W-1:0] new_val;
    logic [CAP_W-1:0] old_val;
    logic [OVF_W-1:0] ovf_sel;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser[0];
    assign ch       = s_tuser[1];
    assign new_val  = s_tdata[CAP_W-1:0] & CAP_MASK;
    assign old_val  = last_reg[ch] & CAP_MASK;
    assign ovf_sel  = ovf_reg[ch];

    assign q_push            = accept && (func == FUNC_CAPTURE);
    assign q_entry.channel   = ch;
    assign q_entry.elapsed   = (ELAPSED_W'(ovf_sel) << COUNTER_BITS)
                             + ELAPSED_W'(new_val) - ELAPSED_W'(old_val);
    assign q_entry.numerator = (ch == REG_NUM_B) ? num_b : num_a;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            last_next[i] = last_reg[i];
            ovf_next[i]  = ovf_reg[i];
            if (accept) begin
                if (func == FUNC_OVERFLOW) begin
                    if (ovf_reg[i] != OVF_MAX) begin
                        ovf_next[i] = ovf_reg[i] + OVF_W'(1);
                    end
                end else if (ch == 1'(i)) begin
                    last_next[i] = new_val;
                    ovf_next[i]  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                last_reg[i] <= '0;
                ovf_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < 2; i++) begin
                last_reg[i] <= last_next[i];
                ovf_reg[i]  <= ovf_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dcsm_queue.sv
`default_nettype none

module dcsm_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire dcsm_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output dcsm_pkg::entry_t      pop_entry,
    output logic                  empty
);
    import dcsm_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dcsm_back.sv
`default_nettype none

module dcsm_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire dcsm_pkg::entry_t                q_entry,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dcsm_pkg::OUT_DATA_W-1:0]      m_tdata,  // elapsed_ticks, speed
    output logic [dcsm_pkg::OUT_USER_W-1:0]      m_tuser   // out_channel, zero_interval
);
    import dcsm_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 ch_reg;
    logic                 ch_next;
    logic [ELAPSED_W-1:0] dvs_reg;
    logic [ELAPSED_W-1:0] dvs_next;
    logic [NUM_W-1:0]     dvd_reg;
    logic [NUM_W-1:0]     dvd_next;
    logic [ELAPSED_W-1:0] rem_reg;
    logic [ELAPSED_W-1:0] rem_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_load;
    logic                 out_ch_reg;
    logic                 out_zero_reg;
    logic [ELAPSED_W-1:0] out_elapsed_reg;
    logic [SPEED_W-1:0]   out_speed_reg;

    logic [ELAPSED_W:0]   rem_sh;
    logic [ELAPSED_W:0]   diff;
    logic                 q_bit;
    logic                 zero_flag;

    assign rem_sh    = {rem_reg, dvd_reg[NUM_W-1]};
    assign diff      = rem_sh - {1'b0, dvs_reg};
    assign q_bit     = !diff[ELAPSED_W];
    assign zero_flag = (dvs_reg == '0);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        dvs_next       = dvs_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            BACK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    ch_next    = q_entry.channel;
                    dvs_next   = q_entry.elapsed;
                    dvd_next   = q_entry.numerator;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = BACK_DIV;
                end
            end
            BACK_DIV: begin
                rem_next  = q_bit ? diff[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];
                dvd_next  = {dvd_reg[NUM_W-2:0], q_bit};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BACK_IDLE;
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        ch_reg   <= ch_next;
        dvs_reg  <= dvs_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        if (out_load) begin
            out_ch_reg      <= ch_reg;
            out_zero_reg    <= zero_flag;
            out_elapsed_reg <= dvs_reg;
            out_speed_reg   <= zero_flag ? {SPEED_W{1'b1}} : dvd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_speed_reg, out_elapsed_reg};
    assign m_tuser  = {out_zero_reg, out_ch_reg};

endmodule

`default_nettype wire

FILE: hdl/dual_capture_speed_meter_top.sv
// Two-channel wheel speed meter on a free-running 16-bit timer.
// Input stream: s_tdata carries the captured timer count, s_tuser[0] the kind
// of item (capture or timer overflow) and s_tuser[1] the capturing channel.
// An overflow item bumps both channels' saturating overflow counts in the
// cycle it is taken and gives no result. A capture item gives one result on
// the output stream: m_tdata holds the elapsed ticks (low word) and the
// Q16.16 speed (high word), m_tuser holds the channel and the zero-interval
// flag. The speed comes from a shared radix-2 divider. The back end loads
// a capture from the queue, runs the division and then hands the result to
// the output register; it takes the next capture only after that hand-off.
// A two-entry queue between the front and the divider absorbs bursts;
// the input stalls only when it is full.
// A finished result waits in the output register while the divider works on
// the next capture; a stalled receiver holds the divider once it is done.
// Reset (aresetn low, synchronous) clears the stored captures, the overflow
// counts, the queue and the output, and restores the speed numerators, which
// are written over the APB port at byte addresses 0 and 4.
`default_nettype none

`include "assert_macros.svh"

module dual_capture_speed_meter_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dcsm_pkg::IN_DATA_W-1:0]  s_tdata,  // capture_value
    input  wire logic [dcsm_pkg::IN_USER_W-1:0]  s_tuser,  // func, channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dcsm_pkg::OUT_DATA_W-1:0]      m_tdata,  // elapsed_ticks, speed
    output logic [dcsm_pkg::OUT_USER_W-1:0]      m_tuser,  // out_channel, zero_interval
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dcsm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dcsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dcsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import dcsm_pkg::*;

    logic [NUM_W-1:0] num_a_reg;
    logic [NUM_W-1:0] num_b_reg;
    logic             cfg_we;
    logic             cfg_sel;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    entry_t           push_entry;
    entry_t           pop_entry;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[APB_ADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_a_reg <= NUM_A_RESET;
            num_b_reg <= NUM_B_RESET;
        end else if (cfg_we) begin
            unique case (cfg_sel)
                REG_NUM_A: num_a_reg <= pwdata[NUM_W-1:0];
                REG_NUM_B: num_b_reg <= pwdata[NUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_NUM_A: prdata = APB_DATA_W'(num_a_reg);
            REG_NUM_B: prdata = APB_DATA_W'(num_b_reg);
            default:   prdata = '0;
        endcase
    end

    dcsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .num_a    (num_a_reg),
        .num_b    (num_b_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    dcsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    dcsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `DCSM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid && s_tready)
    `DCSM_ASSERT(a_overflow_no_push, aclk, aresetn, s_tvalid && s_tready && (s_tuser[0] == FUNC_OVERFLOW) |-> !q_push)
    `DCSM_ASSERT(a_pop_not_empty, aclk, aresetn, q_pop |-> !q_empty)
    `DCSM_ASSERT(a_full_stalls, aclk, aresetn, q_full && !q_pop |=> !s_tready)

endmodule

`default_nettype wire
